>>> src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by the channel interfaces, the cell and the top level.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int PRI_W    = 8;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_ENQUEUE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ_HEAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ_EXACT = 2'd2;
    localparam logic [OP_W-1:0] OP_DEQ_BELOW = 2'd3;

    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // one queue entry
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRI_W-1:0]   pri;
    } t_slot;

    // operation broadcast to every cell
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [PRI_W-1:0]   pri;
        logic               commit_enq;
        logic               commit_deq;
    } t_cmd;

    // flags a cell hands to its right neighbor
    typedef struct packed {
        logic ge;    // occupied and priority >= key
        logic keep;  // stays in place on a removal
    } t_link;

endpackage

`default_nettype wire

>>> src/spq_if.sv
// Item channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the field widths.
`default_nettype none

interface spq_in_if;
    import spq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRI_W-1:0]          item_priority;

    modport source (output valid, output opcode, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input opcode, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] removed_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output removed_value, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input occupancy, output ready);
endinterface

`default_nettype wire

>>> src/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the key
// and takes its own, the new, the left or the right entry. Uses spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire spq_pkg::t_cmd i_cmd,
    input  wire logic [CW-1:0] i_count,
    input  wire spq_pkg::t_link i_left,
    input  wire spq_pkg::t_slot i_left_slot,
    input  wire spq_pkg::t_slot i_right_slot,
    output spq_pkg::t_slot     o_slot,
    output spq_pkg::t_link     o_link,
    output logic               o_hit
);
    import spq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;
    logic  w_valid;
    logic  w_ge;
    logic  w_gt;
    logic  w_keep;

    // occupancy is a prefix of the chain
    assign w_valid = i_count > CW'(INDEX);
    assign w_ge    = w_valid && (r_slot.pri >= i_cmd.pri);
    assign w_gt    = w_valid && (r_slot.pri > i_cmd.pri);
    assign w_keep  = (i_cmd.op == OP_DEQ_HEAD) ? 1'b0 : w_gt;

    // first cell past the kept prefix is the removal candidate
    assign o_hit = (i_cmd.op != OP_ENQUEUE) && !w_keep && i_left.keep && w_valid
                   && ((i_cmd.op != OP_DEQ_EXACT) || (r_slot.pri == i_cmd.pri));

    assign o_link = '{ge: w_ge, keep: w_keep};
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.commit_enq) begin
            if (!w_ge) begin
                if (i_left.ge) begin
                    n_slot = '{value: i_cmd.value, pri: i_cmd.pri};
                end else begin
                    n_slot = i_left_slot;
                end
            end
        end else if (i_cmd.commit_deq) begin
            if (!w_keep) begin
                n_slot = i_right_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

`default_nettype wire

>>> src/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: command capture, control FSM,
// cell chain, result collect and output register. Uses spq_pkg, spq_if, spq_cell.
//
//   channel  dir  modport  fields
//   i_in     in   sink     opcode, item_value, item_priority
//   o_out    out  source   removed_value, status, occupancy
//
// The accept edge captures an item in S_IDLE; in S_EXEC it is committed to every
// cell at once and loads the output register, together with the collect of the
// one removal hit across the chain.
// Reset empties the queue at once; slot contents are not cleared.
// A held result stalls the commit and keeps i_in.ready low meanwhile.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state;
    t_state n_state;

    logic [OP_W-1:0]     r_op;
    logic [VALUE_W-1:0]  r_val;
    logic [PRI_W-1:0]    r_pri;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_removed;
    logic [STATUS_W-1:0] r_status;
    logic [OCC_W-1:0]    r_occ;

    logic w_take;
    logic w_go;
    logic w_full;
    logic w_empty;
    logic w_is_enq;
    logic w_found;
    logic [VALUE_W-1:0]  w_sel_val;
    logic [STATUS_W-1:0] w_status;
    t_cmd                w_cmd;

    t_slot            w_slot [DEPTH];
    t_link            w_link [DEPTH];
    logic [DEPTH-1:0] w_hit;

    // ---------------- control FSM ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_EXEC;
            S_EXEC: if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_go       = 1'b0;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_EXEC: w_go = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    assign w_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op  <= i_in.opcode;
            r_val <= i_in.item_value;
            r_pri <= i_in.item_priority;
        end
    end

    // ---------------- cell chain ----------------
    assign w_full   = r_count == CW'(DEPTH);
    assign w_empty  = r_count == '0;
    assign w_is_enq = r_op == OP_ENQUEUE;

    assign w_cmd = '{op: r_op, value: r_val, pri: r_pri,
                     commit_enq: w_go && w_is_enq && !w_full,
                     commit_deq: w_go && !w_is_enq && w_found};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_link w_left;
        t_slot w_left_slot;
        t_slot w_right_slot;

        if (g == 0) begin : g_head
            assign w_left      = '{ge: 1'b1, keep: 1'b1};
            assign w_left_slot = '0;
        end else begin : g_mid
            assign w_left      = w_link[g-1];
            assign w_left_slot = w_slot[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_slot = '0;
        end else begin : g_body
            assign w_right_slot = w_slot[g+1];
        end

        spq_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_count      (r_count),
            .i_left       (w_left),
            .i_left_slot  (w_left_slot),
            .i_right_slot (w_right_slot),
            .o_slot       (w_slot[g]),
            .o_link       (w_link[g]),
            .o_hit        (w_hit[g])
        );
    end

    // at most one hit, so an OR of masked values selects it
    assign w_found = |w_hit;

    always_comb begin
        w_sel_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_val = w_sel_val | (w_slot[i].value & {VALUE_W{w_hit[i]}});
        end
    end

    // ---------------- count and result ----------------
    always_comb begin
        n_count = r_count;
        if (w_cmd.commit_enq) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.commit_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        priority if (w_is_enq) begin
            w_status = w_full ? ST_FULL : ST_ENQUEUED;
        end else if (w_empty) begin
            w_status = ST_EMPTY;
        end else if (w_found) begin
            w_status = ST_REMOVED;
        end else begin
            w_status = ST_NOMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_removed <= (!w_is_enq && w_found) ? w_sel_val : '0;
            r_status  <= w_status;
            r_occ     <= OCC_W'(n_count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = $signed(r_removed);
    assign o_out.status        = r_status;
    assign o_out.occupancy     = r_occ;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_hit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one removal candidate");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit_enq |=> r_count == $past(r_count) + CW'(1))
        else $error("enqueue did not grow the queue");

    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !o_out.ready) |=> r_state == S_EXEC)
        else $error("commit while result register occupied");

endmodule

`default_nettype wire

>>> test/spq_outcome_monitor.sv
`timescale 1ns / 100ps
// Result monitor for the sorted priority queue testbench: tracks the queue contents,
// predicts one outcome per accepted item and compares it with the result channel.
// Depends on spq_pkg and the spq_in_if / spq_out_if channel interfaces.

module spq_outcome_monitor #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if         i_in,
    spq_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending_count,
    output int        o_checked_count
);
    import spq_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic [STATUS_W-1:0]       status;
        logic [OCC_W-1:0]          occupancy;
    } t_outcome;

    // head of the queue at index 0, sorted by descending priority
    t_slot    held_slots[$];
    t_outcome expected_outcomes[$];
    t_outcome due;
    int       fail_tally;
    int       checked_tally;

    function automatic t_outcome apply_queue_op(input logic [OP_W-1:0] op,
                                                input logic signed [VALUE_W-1:0] value,
                                                input logic [PRI_W-1:0] pri);
        t_outcome res;
        t_slot    entry;
        int       pos;
        bit       found;
        res.removed_value = '0;
        res.status = ST_EMPTY;
        if (op == OP_ENQUEUE) begin
            if (held_slots.size() >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // new entry goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < held_slots.size() && held_slots[pos].pri >= pri)
                    pos++;
                entry.value = value;
                entry.pri = pri;
                held_slots.insert(pos, entry);
                res.status = ST_ENQUEUED;
            end
        end else if (held_slots.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            found = (op == OP_DEQ_HEAD);
            pos = 0;
            if (!found) begin
                for (pos = 0; pos < held_slots.size(); pos++) begin
                    if (op == OP_DEQ_EXACT ? (held_slots[pos].pri == pri)
                                           : (held_slots[pos].pri <= pri)) begin
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (found) begin
                res.removed_value = held_slots[pos].value;
                held_slots.delete(pos);
                res.status = ST_REMOVED;
            end else begin
                res.status = ST_NOMATCH;
            end
        end
        res.occupancy = OCC_W'(held_slots.size());
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_slots.delete();
            expected_outcomes.delete();
        end else begin
            // a result always belongs to an item accepted earlier, so check before predicting
            if (i_out.valid && i_out.ready) begin
                checked_tally++;
                if (expected_outcomes.size() == 0) begin
                    $error("result with no item pending: removed_value %0d status %0d occupancy %0d",
                           i_out.removed_value, i_out.status, i_out.occupancy);
                    fail_tally++;
                end else begin
                    due = expected_outcomes.pop_front();
                    if (i_out.removed_value !== due.removed_value) begin
                        $error("removed_value: expected %0d, actual %0d",
                               due.removed_value, i_out.removed_value);
                        fail_tally++;
                    end
                    if (i_out.status !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, i_out.status);
                        fail_tally++;
                    end
                    if (i_out.occupancy !== due.occupancy) begin
                        $error("occupancy: expected %0d, actual %0d",
                               due.occupancy, i_out.occupancy);
                        fail_tally++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_outcomes.push_back(apply_queue_op(i_in.opcode, i_in.item_value,
                                                           i_in.item_priority));
        end
        o_fail_count <= fail_tally;
        o_pending_count <= expected_outcomes.size();
        o_checked_count <= checked_tally;
    end

endmodule

>>> test/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for sorted_priority_queue_unit: clock, reset, item stimulus, result
// stalls, watchdog and verdict. Uses spq_pkg, the channel interfaces and spq_outcome_monitor.

module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 185;
    localparam int IDLE_PCT       = 22;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady_flow;
    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   idle_cycles;
    int   ops_sent[4];

    spq_in_if  req_ch();
    spq_out_if rsp_ch();

    sorted_priority_queue_unit #(.DEPTH(DEPTH_DEFAULT)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    spq_outcome_monitor #(.DEPTH(DEPTH_DEFAULT)) monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (req_ch),
        .i_out           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                             input logic [PRI_W-1:0] pri);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.item_value <= value;
        req_ch.item_priority <= pri;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        ops_sent[op]++;
    endtask

    // hold off the sender until every outstanding item has produced its result
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [PRI_W-1:0] pick_priority(input int spread,
                                                        input logic [PRI_W-1:0] base);
        if (spread >= 256)
            return PRI_W'($urandom_range(255));
        return base + PRI_W'($urandom_range(spread - 1));
    endfunction

    function automatic logic [OP_W-1:0] pick_dequeue();
        case ($urandom_range(3))
            0, 1: return OP_DEQ_HEAD;
            2: return OP_DEQ_EXACT;
            default: return OP_DEQ_BELOW;
        endcase
    endfunction

    initial begin
        int phase;
        int run_left;
        int phase_sent;
        int enq_pct;
        int spread;
        int run_kind;
        logic [PRI_W-1:0] base;
        logic [OP_W-1:0] op;

        i_rst_n <= 1'b0;
        steady_flow <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.opcode <= OP_ENQUEUE;
        req_ch.item_value <= '0;
        req_ch.item_priority <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every dequeue kind on an empty queue
        send_item(OP_DEQ_HEAD, 32'sd0, 8'd0);
        send_item(OP_DEQ_EXACT, 32'sd0, 8'd255);
        send_item(OP_DEQ_BELOW, 32'sd0, 8'd0);
        // equal priorities must keep arrival order
        send_item(OP_ENQUEUE, 32'sh7fff_ffff, 8'd255);
        send_item(OP_ENQUEUE, 32'sd0, 8'd128);
        send_item(OP_ENQUEUE, -32'sd1, 8'd128);
        // no entry at or below 127, none of priority 7
        send_item(OP_DEQ_BELOW, 32'sd0, 8'd127);
        send_item(OP_DEQ_EXACT, 32'sd0, 8'd7);
        send_item(OP_ENQUEUE, 32'sh8000_0000, 8'd0);
        repeat (DEPTH_DEFAULT - 4)
            send_item(OP_ENQUEUE, $urandom, PRI_W'($urandom_range(255)));
        // refused: queue is full
        send_item(OP_ENQUEUE, 32'sh5a5a_a5a5, 8'd200);
        send_item(OP_DEQ_EXACT, 32'sd0, 8'd128);
        send_item(OP_DEQ_BELOW, 32'sd0, 8'd200);
        send_item(OP_DEQ_HEAD, 32'sd0, 8'd0);
        wait_for_drain();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            steady_flow <= (phase == 4);
            enq_pct = $urandom_range(35, 70);
            case (phase % 3)
                0: spread = 256;
                1: spread = 4;
                default: spread = 16;
            endcase
            base = PRI_W'($urandom_range(255));
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                run_kind = $urandom_range(9);
                run_left = (run_kind < 4) ? 18 : 10;
                while (run_left > 0 && phase_sent < PHASE_ITEMS) begin
                    // fill runs only enqueue and can reach the full queue; drain runs only dequeue
                    if (run_kind < 2)
                        op = OP_ENQUEUE;
                    else if (run_kind < 4)
                        op = pick_dequeue();
                    else if ($urandom_range(99) < enq_pct)
                        op = OP_ENQUEUE;
                    else
                        op = pick_dequeue();
                    send_item(op, $urandom, pick_priority(spread, base));
                    run_left--;
                    phase_sent++;
                end
            end
            wait_for_drain();
        end

        steady_flow <= 1'b0;
        req_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d enqueues and %0d head, %0d exact, %0d at-or-below dequeues,",
                 ops_sent[OP_ENQUEUE], ops_sent[OP_DEQ_HEAD], ops_sent[OP_DEQ_EXACT],
                 ops_sent[OP_DEQ_BELOW]);
        $display("full and empty queues included; %0d results compared.", checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
